[hdl/asa_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the atlas slot allocator.
// No dependencies; every other file of the block imports this package.

package asa_pkg;

   // Storage sizes.
   localparam int MAX_BRICKS = 16384;
   localparam int MAX_SLOTS  = 1024;
   localparam int LEVEL_BITS = 4;

   localparam int BRICK_W   = $clog2(MAX_BRICKS);
   localparam int SLOT_W    = $clog2(MAX_SLOTS);
   localparam int COUNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int LEVEL_W   = LEVEL_BITS;
   localparam int LEVEL_TOP = (1 << LEVEL_BITS) - 1;

   // Clearing pass walks the larger of the two memories.
   localparam int CLEAR_DEPTH = (MAX_BRICKS > MAX_SLOTS) ? MAX_BRICKS : MAX_SLOTS;
   localparam int CLEAR_W     = $clog2(CLEAR_DEPTH);

   // Field and register widths.
   localparam int OP_W        = 2;
   localparam int STATUS_W    = 2;
   localparam int CAP_W       = 11;
   localparam int LEVELS_W    = 4;
   localparam int NODES_W     = 14;
   localparam int CSR_DATA_W  = 14;
   localparam int CSR_INDEX_W = 2;

   // Register values after reset.
   localparam int CAP_RESET    = 1024;
   localparam int LEVELS_RESET = 8;
   localparam int NODES_RESET  = 5461;

   // Remainder unit: restoring division, several quotient bits per cycle.
   localparam int DIV_RADIX_BITS = 4;
   localparam int DIV_PAD_W      = ((BRICK_W + DIV_RADIX_BITS - 1) / DIV_RADIX_BITS)
                                   * DIV_RADIX_BITS;
   localparam int DIV_CYCLES     = DIV_PAD_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W      = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;
   localparam int CMP_W          = ((BRICK_W > NODES_W) ? BRICK_W : NODES_W) + 1;

   // Level datapath: 3*m+1 and its floor log base four.
   localparam int TRIPLE_W = ((BRICK_W + 3) / 2) * 2;
   localparam int LOG_W    = $clog2(TRIPLE_W / 2);

   // Operation codes; the spare code behaves as a lookup.
   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 0,
      OP_RELEASE = 1,
      OP_LOOKUP  = 2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK      = 0,
      ST_PRESENT = 1,
      ST_NO_SLOT = 2,
      ST_ABSENT  = 3
   } status_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY = 0,
      CSR_LEVELS   = 1,
      CSR_NODES    = 2
   } csr_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_ALLOC
   } state_type;

   // One slot table entry.
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [LEVEL_W-1:0] level;
   } entry_type;

   typedef struct packed {
      logic               en;
      logic [BRICK_W-1:0] addr;
      entry_type          entry;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [SLOT_W-1:0] data;
   } stk_wr_type;

   // Capacity clamped to the stack depth.
   function automatic logic [COUNT_W-1:0] eff_capacity(input logic [CAP_W-1:0] cap);
      logic [COUNT_W-1:0] result;
      if (int'(cap) > MAX_SLOTS) begin
         result = COUNT_W'(MAX_SLOTS);
      end else begin
         result = COUNT_W'(cap);
      end
      return result;
   endfunction

   // Index of the highest nonzero base-four digit.
   function automatic logic [LOG_W-1:0] floor_log4(input logic [TRIPLE_W-1:0] v);
      logic [LOG_W-1:0] result;
      result = '0;
      for (int k = 1; k < TRIPLE_W / 2; k++) begin
         if (v[2*k +: 2] != 2'b00) begin
            result = LOG_W'(k);
         end
      end
      return result;
   endfunction

   // levels - log - 1, saturated into the level range.
   function automatic logic [LEVEL_W-1:0] level_calc(input logic [LEVELS_W-1:0] levels,
                                                     input logic [LOG_W-1:0]    lg);
      logic [LEVELS_W:0] diff;
      logic [LEVEL_W-1:0] result;
      result = '0;
      diff   = '0;
      if ({1'b0, levels} > (LEVELS_W + 1)'(lg)) begin
         diff = {1'b0, levels} - (LEVELS_W + 1)'(lg) - (LEVELS_W + 1)'(1);
         if (int'(diff) > LEVEL_TOP) begin
            result = LEVEL_W'(LEVEL_TOP);
         end else begin
            result = LEVEL_W'(diff);
         end
      end
      return result;
   endfunction

endpackage

[hdl/asa_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the request and response beats.
// Depends on asa_pkg for the field widths.

interface asa_req_if;
   import asa_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    operation;
   logic [BRICK_W-1:0] brick_index;

   modport source (output valid, output operation, output brick_index, input ready);
   modport sink   (input valid, input operation, input brick_index, output ready);
endinterface

interface asa_rsp_if;
   import asa_pkg::*;

   logic                valid;
   logic                ready;
   logic [SLOT_W-1:0]   slot;
   logic [LEVEL_W-1:0]  level;
   logic                present;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output slot, output level, output present,
                   output status, input ready);
   modport sink   (input valid, input slot, input level, input present,
                   input status, output ready);
endinterface

[hdl/asa_slot_table.sv]
`timescale 1ns / 1ps
// Per-brick mapping memory: one write port, one registered read port.
// Depends on asa_pkg for the entry and write-port types.

module asa_slot_table (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [asa_pkg::BRICK_W-1:0] rd_addr,
   output asa_pkg::entry_type          rd_entry,
   input  asa_pkg::tbl_wr_type         wr
);
   import asa_pkg::*;

   entry_type table_mem [MAX_BRICKS];
   entry_type rd_entry_ff;

   // Synchronous write and read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         table_mem[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry_ff <= table_mem[rd_addr];
      end
   end

   assign rd_entry = rd_entry_ff;

endmodule

[hdl/asa_free_stack.sv]
`timescale 1ns / 1ps
// Free-slot stack storage: one write port, one registered read port.
// Depends on asa_pkg for widths and the write-port type.

module asa_free_stack (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [asa_pkg::SLOT_W-1:0] rd_addr,
   output logic [asa_pkg::SLOT_W-1:0] rd_data,
   input  asa_pkg::stk_wr_type        wr
);
   import asa_pkg::*;

   logic [SLOT_W-1:0] stack_mem [MAX_SLOTS];
   logic [SLOT_W-1:0] rd_data_ff;

   // Synchronous write and read; read data holds until the next read.
   always_ff @(posedge clock) begin
      if (wr.en) begin
         stack_mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= stack_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/asa_remainder.sv]
`timescale 1ns / 1ps
// Iterative remainder unit: brick index modulo the configured node count.
// Depends on asa_pkg for widths and the per-cycle step count.

module asa_remainder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [asa_pkg::BRICK_W-1:0] dividend,
   input  logic [asa_pkg::NODES_W-1:0] divisor,
   output logic                        done,
   output logic [asa_pkg::BRICK_W-1:0] remainder
);
   import asa_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [BRICK_W-1:0]   rem_ff, rem_in;
   logic [DIV_PAD_W-1:0] bits_ff, bits_in;

   // Several restoring steps per cycle. A zero divisor subtracts nothing,
   // so the remainder comes out equal to the dividend.
   always_comb begin
      logic [CMP_W-1:0] r;
      r       = CMP_W'(rem_ff);
      busy_in = busy_ff;
      done_in = done_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      bits_in = bits_ff;
      for (int k = 0; k < DIV_RADIX_BITS; k++) begin
         r = {r[CMP_W-2:0], bits_ff[DIV_PAD_W-1-k]};
         if (r >= CMP_W'(divisor)) begin
            r = r - CMP_W'(divisor);
         end
      end
      if (start) begin
         busy_in = 1'b1;
         done_in = 1'b0;
         cnt_in  = '0;
         rem_in  = '0;
         bits_in = DIV_PAD_W'(dividend);
      end else if (busy_ff) begin
         rem_in  = r[BRICK_W-1:0];
         bits_in = bits_ff << DIV_RADIX_BITS;
         cnt_in  = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control flags reset; the datapath registers do not need it.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      bits_ff <= bits_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

[hdl/atlas_slot_allocator_top.sv]
`timescale 1ns / 1ps
// Top level of the atlas slot allocator: control sequencer, registers, output stage.
// Depends on asa_pkg, asa_if, asa_slot_table, asa_free_stack and asa_remainder.
//
//   Channel  Direction  Handshake          Payload
//   req_if   in         valid / ready      operation, brick_index
//   rsp_if   out        valid / ready      slot, level, present, status
//   csr_*    in         csr_write_en only  csr_index, csr_write_data
//
// Lookup, release and a failing allocate pass from S_IDLE through S_EVAL and back
// to S_IDLE; a successful allocate also waits in S_ALLOC for the remainder unit
// that reduces the brick index modulo the node count. Only S_IDLE takes a new beat.
// After reset and after every register write, a clearing pass walks all 16384
// slot table entries (and refills the stack's 1024 entries as it goes); no
// request beat is taken during it. The output register frees the request side
// while a response beat waits; a stalled response holds the sequencer.

module atlas_slot_allocator_top (
   input  logic                            clock,
   input  logic                            reset,
   asa_req_if.sink                         req_if,
   asa_rsp_if.source                       rsp_if,
   input  logic                            csr_write_en,
   input  logic [asa_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asa_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import asa_pkg::*;

   state_type           state_ff, state_in;
   logic [CLEAR_W-1:0]  clear_cnt_ff, clear_cnt_in;
   logic [CAP_W-1:0]    cap_ff, cap_in;
   logic [LEVELS_W-1:0] levels_ff, levels_in;
   logic [NODES_W-1:0]  nodes_ff, nodes_in;
   logic [COUNT_W-1:0]  free_count_ff, free_count_in;
   logic [OP_W-1:0]     op_ff;
   logic [BRICK_W-1:0]  brick_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_level_in;
   logic                rsp_present_ff, rsp_present_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic                accept;
   logic                csr_hit;
   logic                out_free;
   entry_type           tbl_entry;
   tbl_wr_type          tbl_wr;
   logic [SLOT_W-1:0]   stk_data;
   stk_wr_type          stk_wr;
   logic                div_done;
   logic [BRICK_W-1:0]  div_rem;
   logic [TRIPLE_W-1:0] triple;
   logic [LEVEL_W-1:0]  new_level;

   assign req_if.ready = (state_ff == S_IDLE) && !csr_write_en;
   assign accept       = req_if.valid && req_if.ready;
   assign out_free     = !rsp_valid_ff || rsp_if.ready;

   // Register writes; any of the three restarts the clearing pass.
   always_comb begin
      cap_in    = cap_ff;
      levels_in = levels_ff;
      nodes_in  = nodes_ff;
      csr_hit   = 1'b0;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_CAPACITY: begin
               cap_in  = csr_write_data[CAP_W-1:0];
               csr_hit = 1'b1;
            end
            CSR_LEVELS: begin
               levels_in = csr_write_data[LEVELS_W-1:0];
               csr_hit   = 1'b1;
            end
            CSR_NODES: begin
               nodes_in = csr_write_data[NODES_W-1:0];
               csr_hit  = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
   end

   // Level of a new mapping from the remainder: 3*m+1, floor log4, saturate.
   assign triple    = TRIPLE_W'(div_rem) + (TRIPLE_W'(div_rem) << 1) + TRIPLE_W'(1);
   assign new_level = level_calc(levels_ff, floor_log4(triple));

   // Sequencer: next state, memory writes and the response beat.
   always_comb begin
      logic              had;
      logic              finish;
      logic [SLOT_W-1:0] cur_slot;
      logic [LEVEL_W-1:0] cur_level;
      logic [STATUS_W-1:0] status;

      had       = tbl_entry.valid;
      cur_slot  = had ? tbl_entry.slot : '0;
      cur_level = had ? tbl_entry.level : '0;
      finish    = 1'b0;
      status    = ST_OK;

      state_in       = state_ff;
      clear_cnt_in   = clear_cnt_ff;
      free_count_in  = free_count_ff;
      tbl_wr         = '0;
      stk_wr         = '0;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_slot_in    = rsp_slot_ff;
      rsp_level_in   = rsp_level_ff;
      rsp_present_in = rsp_present_ff;
      rsp_status_in  = rsp_status_ff;

      if (csr_hit) begin
         state_in      = S_CLEAR;
         clear_cnt_in  = '0;
         free_count_in = eff_capacity(cap_in);
      end else begin
         unique case (state_ff)
            // Invalidate the table and put slot i back at stack entry i.
            S_CLEAR: begin
               if (int'(clear_cnt_ff) < MAX_BRICKS) begin
                  tbl_wr.en   = 1'b1;
                  tbl_wr.addr = BRICK_W'(clear_cnt_ff);
               end
               if (int'(clear_cnt_ff) < MAX_SLOTS) begin
                  stk_wr.en   = 1'b1;
                  stk_wr.addr = SLOT_W'(clear_cnt_ff);
                  stk_wr.data = SLOT_W'(clear_cnt_ff);
               end
               if (clear_cnt_ff == CLEAR_W'(CLEAR_DEPTH - 1)) begin
                  state_in = S_IDLE;
               end else begin
                  clear_cnt_in = clear_cnt_ff + CLEAR_W'(1);
               end
            end

            S_IDLE: begin
               if (accept) begin
                  state_in = S_EVAL;
               end
            end

            // Table entry and stack top are ready; decide the operation.
            S_EVAL: begin
               unique case (op_ff)
                  OP_ALLOC: begin
                     if (had) begin
                        finish = 1'b1;
                        status = ST_PRESENT;
                     end else if (free_count_ff == '0) begin
                        finish = 1'b1;
                        status = ST_NO_SLOT;
                     end else begin
                        state_in = S_ALLOC;
                     end
                  end
                  OP_RELEASE: begin
                     finish = 1'b1;
                     status = had ? ST_OK : ST_ABSENT;
                  end
                  default: begin
                     finish = 1'b1;
                     status = had ? ST_OK : ST_ABSENT;
                  end
               endcase
               if (finish && out_free) begin
                  state_in       = S_IDLE;
                  rsp_valid_in   = 1'b1;
                  rsp_slot_in    = cur_slot;
                  rsp_level_in   = cur_level;
                  rsp_present_in = had;
                  rsp_status_in  = status;
                  // Release of a held slot: invalidate, push if there is room.
                  if (op_ff == OP_RELEASE && had) begin
                     tbl_wr.en   = 1'b1;
                     tbl_wr.addr = brick_ff;
                     if (free_count_ff < eff_capacity(cap_ff)) begin
                        stk_wr.en     = 1'b1;
                        stk_wr.addr   = free_count_ff[SLOT_W-1:0];
                        stk_wr.data   = tbl_entry.slot;
                        free_count_in = free_count_ff + COUNT_W'(1);
                     end
                  end
               end
            end

            // New mapping: wait for the remainder, then pop and store.
            S_ALLOC: begin
               if (div_done && out_free) begin
                  state_in           = S_IDLE;
                  tbl_wr.en          = 1'b1;
                  tbl_wr.addr        = brick_ff;
                  tbl_wr.entry.valid = 1'b1;
                  tbl_wr.entry.slot  = stk_data;
                  tbl_wr.entry.level = new_level;
                  free_count_in      = free_count_ff - COUNT_W'(1);
                  rsp_valid_in       = 1'b1;
                  rsp_slot_in        = stk_data;
                  rsp_level_in       = new_level;
                  rsp_present_in     = 1'b0;
                  rsp_status_in      = ST_OK;
               end
            end

            default: begin
               state_in = S_CLEAR;
            end
         endcase
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_cnt_ff  <= '0;
         cap_ff        <= CAP_W'(CAP_RESET);
         levels_ff     <= LEVELS_W'(LEVELS_RESET);
         nodes_ff      <= NODES_W'(NODES_RESET);
         free_count_ff <= eff_capacity(CAP_W'(CAP_RESET));
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_cnt_ff  <= clear_cnt_in;
         cap_ff        <= cap_in;
         levels_ff     <= levels_in;
         nodes_ff      <= nodes_in;
         free_count_ff <= free_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers: the accepted request and the response beat.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_if.operation;
         brick_ff <= req_if.brick_index;
      end
      rsp_slot_ff    <= rsp_slot_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_present_ff <= rsp_present_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.slot    = rsp_slot_ff;
   assign rsp_if.level   = rsp_level_ff;
   assign rsp_if.present = rsp_present_ff;
   assign rsp_if.status  = rsp_status_ff;

   // Both memories are read on the accepting edge; the stack at its top.
   asa_slot_table u_slot_table (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (req_if.brick_index),
      .rd_entry (tbl_entry),
      .wr       (tbl_wr)
   );

   asa_free_stack u_free_stack (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (SLOT_W'(free_count_ff - COUNT_W'(1))),
      .rd_data (stk_data),
      .wr      (stk_wr)
   );

   asa_remainder u_remainder (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (req_if.brick_index),
      .divisor   (nodes_ff),
      .done      (div_done),
      .remainder (div_rem)
   );

endmodule
